@@ src/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, request and status codes and helpers for the slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int unsigned SLOTS    = 32;
  localparam int unsigned IDX_W    = 5;   // slot index width
  localparam int unsigned CNT_W    = 6;   // slot count width, holds SLOTS
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC       = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(SLOTS);

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the request beat
    logic exec;   // apply the request, load the result register
  } bsa_cmd_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] x);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (x[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ src/bsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: takes a beat, runs it once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl
  import bsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bsa_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, exec_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // result register must be empty or draining this cycle
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = exec_go;

endmodule

`default_nettype wire

@@ src/bsa_datapath.sv @@
// ----------------------------------------------------------------------------
// bsa_datapath
// Occupancy bitmap, used count, slot count register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath
  import bsa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bsa_cmd_t            cmd_i,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [IDX_W-1:0]    slot_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CNT_W-1:0]    cfg_wdata_i,
  output logic [IDX_W-1:0]         slot_index_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [CNT_W-1:0]         used_slots_o,
  output logic [CNT_W-1:0]         free_slots_o
);

  logic [CNT_W-1:0]    slot_count_q;
  logic [SLOTS-1:0]    map_q, map_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [FUNC_W-1:0]   func_q;
  logic [IDX_W-1:0]    slot_q;

  logic [CNT_W-1:0]    eff_n;
  logic [SLOTS-1:0]    limit;
  logic [SLOTS-1:0]    avail;
  logic [IDX_W-1:0]    idx_d;
  logic [STATUS_W-1:0] status_d;
  logic [CNT_W-1:0]    free_d;

  assign eff_n = (slot_count_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      limit[i] = (CNT_W'(i) < eff_n);
    end
  end

  assign avail = ~map_q & limit;

  always_comb begin
    map_d    = map_q;
    used_d   = used_q;
    idx_d    = '0;
    status_d = STATUS_OK;
    case (func_q)
      FUNC_ALLOC: begin
        if (avail == '0) begin
          status_d = STATUS_FULL;
        end else begin
          idx_d        = lowest_set(avail);
          map_d[idx_d] = 1'b1;
          used_d       = used_q + CNT_W'(1);
        end
      end
      FUNC_RELEASE: begin
        if ({1'b0, slot_q} >= eff_n || !map_q[slot_q]) begin
          status_d = STATUS_BAD_SLOT;
        end else begin
          idx_d         = slot_q;
          map_d[slot_q] = 1'b0;
          used_d        = used_q - CNT_W'(1);
        end
      end
      FUNC_RELEASE_ALL: begin
        map_d  = '0;
        used_d = '0;
      end
      default: ;
    endcase
    free_d = (eff_n > used_d) ? (eff_n - used_d) : '0;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      slot_q <= slot_i;
    end
  end

  // allocator state; a slot count write restarts with every slot free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      map_q        <= '0;
      used_q       <= '0;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
      map_q        <= '0;
      used_q       <= '0;
    end else if (cmd_i.exec) begin
      map_q  <= map_d;
      used_q <= used_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      slot_index_o <= idx_d;
      status_o     <= status_d;
      used_slots_o <= used_d;
      free_slots_o <= free_d;
    end
  end

endmodule

`default_nettype wire

@@ src/bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Lowest-free-first slot allocator over a 32-entry occupancy bitmap.
// ----------------------------------------------------------------------------
// Each request beat (allocate, release one slot, release all) yields one
// result beat with the slot, a status and the used/free counts after the
// request. A beat is captured in the idle state; in the execute state the
// find-first-free search and the count update run and load the result
// register. A request is not taken until the one before it has executed.
// A new request is accepted while the previous result still waits; it
// then holds in the execute state until the result register frees.
// Writing the slot count frees every slot; write it only while idle.
`default_nettype none

module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [IDX_W-1:0]    slot_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [IDX_W-1:0]         slot_index_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [CNT_W-1:0]         used_slots_o,
  output logic [CNT_W-1:0]         free_slots_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CNT_W-1:0]    cfg_wdata_i
);

  bsa_cmd_t cmd;

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bsa_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .slot_index_o (slot_index_o),
    .status_o     (status_o),
    .used_slots_o (used_slots_o),
    .free_slots_o (free_slots_o)
  );

`ifndef ASSERT_OFF
  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // a refused request never reports a slot
  a_refused_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_BAD_SLOT))
      |-> (slot_index_o == '0))
    else $error("refused request reports a slot");

  // used plus free never exceeds the slot total
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, used_slots_o} + {1'b0, free_slots_o}) <= (CNT_W+1)'(SLOTS)))
    else $error("used and free counts exceed slot total");

  // a new result only follows an executed request
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request");
`endif

endmodule

`default_nettype wire

@@ sim/alloc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the request, result and slot-count ports of the slot allocator,
// keeps its own occupancy map and compares every result beat with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------

module alloc_checker
  import bsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [FUNC_W-1:0]   req_func_i,
  input  logic [IDX_W-1:0]    req_slot_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  logic [IDX_W-1:0]    rsp_slot_i,
  input  logic [STATUS_W-1:0] rsp_status_i,
  input  logic [CNT_W-1:0]    rsp_used_i,
  input  logic [CNT_W-1:0]    rsp_free_i,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  output int                  error_count_o,
  output int                  owed_count_o
);

  typedef struct packed {
    logic [IDX_W-1:0]    slot_index;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    used;
    logic [CNT_W-1:0]    free;
  } alloc_result_t;

  logic [SLOTS-1:0] occ_map;
  logic [CNT_W-1:0] occ_total;
  logic [CNT_W-1:0] slot_limit;
  alloc_result_t    owed_results[$];
  int               errors = 0;

  assign error_count_o = errors;

  // Applies one request to the shadow bitmap and returns the result it owes.
  function automatic alloc_result_t apply_request(input logic [FUNC_W-1:0] f,
                                                  input logic [IDX_W-1:0] s);
    alloc_result_t    r;
    logic [CNT_W-1:0] n;
    logic             found;
    r = '0;
    found = 1'b0;
    // slots past the physical bitmap are never usable
    n = (slot_limit > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_limit;
    case (f)
      FUNC_ALLOC: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && i < n && !occ_map[i]) begin
            found = 1'b1;
            r.slot_index = IDX_W'(i);
          end
        end
        if (found) begin
          occ_map[r.slot_index] = 1'b1;
          occ_total = occ_total + 1'b1;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      FUNC_RELEASE: begin
        if (CNT_W'(s) >= n || !occ_map[s]) begin
          r.status = STATUS_BAD_SLOT;
        end else begin
          r.slot_index = s;
          occ_map[s] = 1'b0;
          occ_total = occ_total - 1'b1;
        end
      end
      FUNC_RELEASE_ALL: begin
        occ_map = '0;
        occ_total = '0;
      end
      default: ;
    endcase
    r.used = occ_total;
    r.free = (n > occ_total) ? n - occ_total : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_ni) begin
      slot_limit = SLOT_COUNT_RST;
      occ_map = '0;
      occ_total = '0;
      owed_results.delete();
      owed_count_o <= 0;
    end else begin
      // a slot-count write also frees every slot
      if (cfg_we_i) begin
        slot_limit = cfg_wdata_i;
        occ_map = '0;
        occ_total = '0;
      end
      // retire before predicting: a result can never belong to this edge's request
      if (rsp_valid_i && rsp_ready_i) begin
        got = {rsp_slot_i, rsp_status_i, rsp_used_i, rsp_free_i};
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result beat slot=%0d status=%0d used=%0d free=%0d",
                     $time, got.slot_index, got.status, got.used, got.free);
          end
        end else begin
          want = owed_results.pop_front();
          if (want.slot_index !== got.slot_index || want.status !== got.status ||
              want.used !== got.used || want.free !== got.free) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp slot=%0d status=%0d used=%0d free=%0d",
                       $time, want.slot_index, want.status, want.used, want.free);
              $display("%0t:          got slot=%0d status=%0d used=%0d free=%0d",
                       $time, got.slot_index, got.status, got.used, got.free);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        owed_results.push_back(apply_request(req_func_i, req_slot_i));
      end
      owed_count_o <= owed_results.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bitmap slot allocator.
// Runs a directed sequence over the corner slot counts, then random
// allocate/release traffic across several slot-count settings with sender
// gaps, receiver stalls and a long output hold-off; alloc_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------

module testbench;
  import bsa_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES     = 80;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0] PHASE_COUNTS [12] =
    '{6'd32, 6'd7, 6'd1, 6'd63, 6'd0, 6'd20, 6'd32, 6'd3, 6'd33, 6'd2, 6'd32, 6'd12};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i;
  logic [IDX_W-1:0]    slot_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IDX_W-1:0]    slot_index_o;
  logic [STATUS_W-1:0] status_o;
  logic [CNT_W-1:0]    used_slots_o;
  logic [CNT_W-1:0]    free_slots_o;
  logic                cfg_we_i;
  logic [CNT_W-1:0]    cfg_wdata_i;

  int   errors;
  int   owed;
  int   cycles = 0;
  int   sent = 0;
  int   settings = 0;
  int   usable = 32;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_kick = 1'b0;
  int   hold_left = 0;
  logic hold_taken = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  bitmap_slot_allocator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slot_index_o (slot_index_o),
    .status_o     (status_o),
    .used_slots_o (used_slots_o),
    .free_slots_o (free_slots_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_i   (in_ready_o),
    .req_func_i    (func_i),
    .req_slot_i    (slot_i),
    .rsp_valid_i   (out_valid_o),
    .rsp_ready_i   (out_ready_i),
    .rsp_slot_i    (slot_index_o),
    .rsp_status_i  (status_o),
    .rsp_used_i    (used_slots_o),
    .rsp_free_i    (free_slots_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .error_count_o (errors),
    .owed_count_o  (owed)
  );

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_kick && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, owed);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    slot_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  task automatic set_slot_count(input logic [CNT_W-1:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    usable = (v > CNT_W'(SLOTS)) ? SLOTS : int'(v);
    settings++;
  endtask

  // Mostly allocate and release in-range slots so the map fills and drains.
  task automatic send_random();
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  s;
    int                r;
    r = $urandom_range(99);
    s = IDX_W'($urandom_range(31));
    if (r < 52) begin
      f = FUNC_ALLOC;
    end else if (r < 98) begin
      f = FUNC_RELEASE;
      if (usable > 0 && $urandom_range(9) < 8) s = IDX_W'($urandom_range(usable - 1));
    end else if (r == 98) begin
      f = FUNC_RELEASE_ALL;
    end else begin
      f = FUNC_UNUSED;
    end
    send_req(f, s);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_ALLOC;
    slot_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset slot count of 32
    send_req(FUNC_ALLOC, 5'd0);
    send_req(FUNC_ALLOC, 5'd31);
    send_req(FUNC_ALLOC, 5'd0);
    send_req(FUNC_RELEASE, 5'd1);
    send_req(FUNC_ALLOC, 5'd0);       // lowest free is 1 again
    send_req(FUNC_RELEASE, 5'd31);    // never allocated
    send_req(FUNC_RELEASE, 5'd0);
    send_req(FUNC_RELEASE, 5'd0);     // double release
    send_req(FUNC_UNUSED, 5'd31);
    send_req(FUNC_RELEASE_ALL, 5'd0);
    send_req(FUNC_ALLOC, 5'd0);
    // single slot: full and out of range
    set_slot_count(6'd1);
    send_req(FUNC_ALLOC, 5'd0);
    send_req(FUNC_ALLOC, 5'd0);
    send_req(FUNC_RELEASE, 5'd1);
    send_req(FUNC_RELEASE, 5'd0);
    send_req(FUNC_RELEASE, 5'd0);
    // no slots at all
    set_slot_count(6'd0);
    send_req(FUNC_ALLOC, 5'd0);
    send_req(FUNC_RELEASE, 5'd0);
    send_req(FUNC_RELEASE_ALL, 5'd31);
    // count above the bitmap size is capped
    set_slot_count(6'd63);
    send_req(FUNC_ALLOC, 5'd0);
    send_req(FUNC_RELEASE, 5'd31);
    send_req(FUNC_RELEASE, 5'd0);

    for (int p = 0; p < 12; p++) begin
      set_slot_count(PHASE_COUNTS[p]);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 46;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 46;
        end
        default: begin
          tx_idle_pct = 6;
          rx_stall_pct <= 6;
        end
      endcase
      // back-to-back requests against a blocked result port
      if (p == 4) hold_kick <= 1'b1;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("Ran %0d requests over %0d slot-count writes (0, 1, 32 and 63 included),",
             sent, settings);
    $display("with sender gaps, result stalls, one long result hold-off and full drains.");
    if (errors == 0 && owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bsa_pkg.sv
src/bsa_ctrl.sv
src/bsa_datapath.sv
src/bitmap_slot_allocator.sv
sim/alloc_checker.sv
sim/testbench.sv
